@@ rtl/bcd_watch_mode_controller_macros.svh @@
// Assertion macros for the watch mode controller checker.
// Each macro takes a label, the clock, the active-low reset and the property terms.
`ifndef BCD_WATCH_MODE_CONTROLLER_MACROS_SVH
`define BCD_WATCH_MODE_CONTROLLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCDWM_ASSERT_SAME(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bcdwm same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BCDWM_ASSERT_NEXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bcdwm next-cycle check failed");

`endif

@@ rtl/bcdwm_pkg.sv @@
// Shared types and constants for the watch mode controller.
// Used by the top level and its port checker; depends on nothing.
`timescale 1ns / 1ps

package bcdwm_pkg;

	typedef enum logic [1:0] {
		MODE_SLEEP       = 2'd0,
		MODE_DISPLAY     = 2'd1,
		MODE_SET_HOURS   = 2'd2,
		MODE_SET_MINUTES = 2'd3
	} mode_t;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 8;

	localparam logic [CFG_INDEX_W-1:0] CFG_WAKE_TIMEOUT   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_RETURN_TIMEOUT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_LOCKOUT_TICKS  = 2'd2;

	localparam logic CMD_TICK   = 1'b0;
	localparam logic CMD_BUTTON = 1'b1;

	localparam logic [7:0] WAKE_TIMEOUT_RST   = 8'd10;
	localparam logic [7:0] RETURN_TIMEOUT_RST = 8'd15;
	localparam logic [3:0] LOCKOUT_TICKS_RST  = 4'd2;
	localparam logic [7:0] TIMEOUT_COUNT_RST  = 8'd15;

	localparam logic [5:0] SECONDS_PER_MINUTE = 6'd60;

	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 16;

	// Layout of the result word.
	localparam int OUT_MODE_LSB = 0;
	localparam int OUT_HT_LSB   = 2;
	localparam int OUT_HU_LSB   = 4;
	localparam int OUT_MT_LSB   = 8;
	localparam int OUT_MU_LSB   = 11;
	localparam int OUT_DISP_BIT = 15;

	typedef struct packed {
		logic [1:0] tens;
		logic [3:0] units;
	} hour_digits_t;

	typedef struct packed {
		logic [2:0] tens;
		logic [3:0] units;
	} min_digits_t;

	typedef struct packed {
		logic        wrap;
		min_digits_t digits;
	} min_step_t;

endpackage

@@ rtl/bcd_watch_mode_controller.sv @@
// Watch mode controller top level: event input stage, state update and result register.
// Depends on bcdwm_pkg.
`timescale 1ns / 1ps

// Each accepted event (a one-second tick or a button sample) produces exactly one result
// word showing the mode and the hh:mm time after that event. An event is registered in the
// input stage, the state is updated from it, and the result lands in the output register
// together with the new state. One event is taken every cycle while the output is not stalled;
// the single state update per cycle sets that rate, and an event may follow its predecessor
// directly because the new state is registered and fed straight back to the update logic.
// Configuration writes are meant to be made while no event is in flight.
module bcd_watch_mode_controller
	import bcdwm_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_DATA_W-1:0]   s_axis_tdata,  // [0] button_down, others zero
	input  logic                   s_axis_tuser,  // [0] cmd
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [1:0] mode, [3:2] hour_tens, [7:4] hour_units, [10:8] minute_tens,
	// [14:11] minute_units, [15] display_on
	output logic [OUT_DATA_W-1:0]  m_axis_tdata,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	function automatic hour_digits_t step_hours(input hour_digits_t h);
		hour_digits_t r;
		r.tens  = h.tens;
		r.units = h.units + 4'd1;
		if (r.units >= 4'd10) begin
			r.units = 4'd0;
			r.tens  = (h.tens < 2'd2) ? h.tens + 2'd1 : 2'd0;
		end
		if (r.tens >= 2'd2 && r.units >= 4'd4) begin
			r.tens  = 2'd0;
			r.units = 4'd0;
		end
		return r;
	endfunction

	function automatic min_step_t step_minutes(input min_digits_t m);
		min_step_t r;
		r.wrap         = 1'b0;
		r.digits.tens  = m.tens;
		r.digits.units = m.units + 4'd1;
		if (r.digits.units >= 4'd10) begin
			r.digits.units = 4'd0;
			r.digits.tens  = m.tens + 3'd1;
		end
		if (r.digits.tens >= 3'd6) begin
			r.digits.tens  = 3'd0;
			r.digits.units = 4'd0;
			r.wrap         = 1'b1;
		end
		return r;
	endfunction

	logic [7:0]   wake_timeout_q;
	logic [7:0]   return_timeout_q;
	logic [3:0]   lockout_ticks_q;

	logic         valid_s1;
	logic         cmd_s1;
	logic         button_s1;
	logic         adv_s1;

	mode_t        mode_q, mode_d;
	hour_digits_t hour_q, hour_d, hour_step;
	min_digits_t  min_q, min_d;
	min_step_t    min_step;
	logic [5:0]   sec_q, sec_d, sec_inc;
	logic [7:0]   tmo_q, tmo_d;
	logic         en_q, en_d;
	logic [3:0]   lock_q, lock_d, lock_inc, lock_lim;

	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	assign adv_s1        = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wake_timeout_q   <= WAKE_TIMEOUT_RST;
			return_timeout_q <= RETURN_TIMEOUT_RST;
			lockout_ticks_q  <= LOCKOUT_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WAKE_TIMEOUT:   wake_timeout_q   <= cfg_data;
				CFG_RETURN_TIMEOUT: return_timeout_q <= cfg_data;
				CFG_LOCKOUT_TICKS:  lockout_ticks_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cmd_s1    <= s_axis_tuser;
			button_s1 <= s_axis_tdata[0];
		end
	end

	always_comb begin
		mode_d    = mode_q;
		hour_d    = hour_q;
		min_d     = min_q;
		sec_d     = sec_q;
		tmo_d     = tmo_q;
		en_d      = en_q;
		lock_d    = lock_q;
		lock_inc  = lock_q + 4'd1;
		lock_lim  = (lockout_ticks_q == 4'd0) ? 4'd1 : lockout_ticks_q;
		sec_inc   = sec_q + 6'd1;
		min_step  = step_minutes(min_q);
		hour_step = step_hours(hour_q);
		if (cmd_s1 == CMD_TICK) begin
			if (!en_q) begin
				lock_d = lock_inc;
				if (lock_inc >= lock_lim) begin
					en_d   = 1'b1;
					lock_d = 4'd0;
				end
			end
			case (mode_q)
				MODE_SLEEP, MODE_DISPLAY: begin
					if (sec_inc >= SECONDS_PER_MINUTE) begin
						sec_d = 6'd0;
						min_d = min_step.digits;
						if (min_step.wrap) begin
							hour_d = hour_step;
						end
					end else begin
						sec_d = sec_inc;
					end
					if (mode_q == MODE_DISPLAY) begin
						if (tmo_q <= 8'd1) begin
							tmo_d  = 8'd0;
							mode_d = MODE_SLEEP;
						end else begin
							tmo_d = tmo_q - 8'd1;
						end
					end
				end
				MODE_SET_HOURS: hour_d = hour_step;
				default: min_d = min_step.digits;
			endcase
		end else if (button_s1) begin
			if (mode_q == MODE_SLEEP) begin
				mode_d = MODE_DISPLAY;
				tmo_d  = wake_timeout_q;
				en_d   = 1'b0;
			end else if (en_q) begin
				en_d = 1'b0;
				case (mode_q)
					MODE_DISPLAY:   mode_d = MODE_SET_HOURS;
					MODE_SET_HOURS: mode_d = MODE_SET_MINUTES;
					default: begin
						mode_d = MODE_DISPLAY;
						tmo_d  = return_timeout_q;
						sec_d  = 6'd0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SLEEP;
			hour_q <= '0;
			min_q  <= '0;
			sec_q  <= 6'd0;
			tmo_q  <= TIMEOUT_COUNT_RST;
			en_q   <= 1'b1;
			lock_q <= 4'd0;
		end else if (valid_s1 && adv_s1) begin
			mode_q <= mode_d;
			hour_q <= hour_d;
			min_q  <= min_d;
			sec_q  <= sec_d;
			tmo_q  <= tmo_d;
			en_q   <= en_d;
			lock_q <= lock_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s1) begin
			out_data_q <= {mode_d != MODE_SLEEP, min_d.units, min_d.tens,
				hour_d.units, hour_d.tens, mode_d};
		end
	end

endmodule

@@ rtl/bcdwm_checker.sv @@
// Port-level checker for the watch mode controller, bound to the top level.
// Depends on bcdwm_pkg and bcd_watch_mode_controller_macros.svh.
`timescale 1ns / 1ps
`include "bcd_watch_mode_controller_macros.svh"

module bcdwm_checker
	import bcdwm_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata
);

	logic [1:0] mode_w;
	logic [1:0] ht_w;
	logic [3:0] hu_w;
	logic [2:0] mt_w;
	logic [3:0] mu_w;
	logic       disp_w;
	logic       time_ok;

	assign mode_w  = m_axis_tdata[OUT_MODE_LSB +: 2];
	assign ht_w    = m_axis_tdata[OUT_HT_LSB +: 2];
	assign hu_w    = m_axis_tdata[OUT_HU_LSB +: 4];
	assign mt_w    = m_axis_tdata[OUT_MT_LSB +: 3];
	assign mu_w    = m_axis_tdata[OUT_MU_LSB +: 4];
	assign disp_w  = m_axis_tdata[OUT_DISP_BIT];
	assign time_ok = (ht_w <= 2'd2) && (hu_w <= 4'd9) && !(ht_w == 2'd2 && hu_w >= 4'd4)
		&& (mt_w <= 3'd5) && (mu_w <= 4'd9);

	`BCDWM_ASSERT_SAME(a_display_matches_mode, clk, arst_n, m_axis_tvalid, disp_w == (mode_w != MODE_SLEEP))
	`BCDWM_ASSERT_SAME(a_time_in_range, clk, arst_n, m_axis_tvalid, time_ok)
	`BCDWM_ASSERT_NEXT(a_valid_holds, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`BCDWM_ASSERT_NEXT(a_data_holds, clk, arst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

endmodule

bind bcd_watch_mode_controller bcdwm_checker u_bcdwm_checker (.*);

@@ sim/tb_bcd_watch_mode_controller.sv @@
// Self-checking testbench for the watch mode controller: ticks and button samples in,
// one hh:mm/mode word out per event, checked against a cycle-free model of the watch.
// Depends on bcdwm_pkg and bcd_watch_mode_controller.
`timescale 1ns / 1ps

typedef struct {
	bcdwm_pkg::mode_t mode;
	logic [1:0]       hour_tens;
	logic [3:0]       hour_units;
	logic [2:0]       minute_tens;
	logic [3:0]       minute_units;
	logic             display_on;
} watch_face_t;

class watch_face_board;
	logic [7:0]       wake_secs;
	logic [7:0]       return_secs;
	logic [3:0]       lockout_len;
	bcdwm_pkg::mode_t cur_mode;
	logic [1:0]       hr_tens;
	logic [3:0]       hr_units;
	logic [2:0]       min_tens;
	logic [3:0]       min_units;
	logic [5:0]       sec_count;
	logic [7:0]       display_left;
	logic             presses_open;
	logic [3:0]       lockout_seen;
	watch_face_t      pending_faces[$];
	int               errors;
	int               faces_checked;
	int               ticks;
	int               samples;
	int               mode_changes;
	int               day_rollovers;

	function new();
		wake_secs = bcdwm_pkg::WAKE_TIMEOUT_RST;
		return_secs = bcdwm_pkg::RETURN_TIMEOUT_RST;
		lockout_len = bcdwm_pkg::LOCKOUT_TICKS_RST;
		cur_mode = bcdwm_pkg::MODE_SLEEP;
		hr_tens = 2'd0;
		hr_units = 4'd0;
		min_tens = 3'd0;
		min_units = 4'd0;
		sec_count = 6'd0;
		display_left = bcdwm_pkg::TIMEOUT_COUNT_RST;
		presses_open = 1'b1;
		lockout_seen = 4'd0;
		errors = 0;
		faces_checked = 0;
		ticks = 0;
		samples = 0;
		mode_changes = 0;
		day_rollovers = 0;
	endfunction

	function void write_reg(logic [1:0] index, logic [7:0] value);
		case (index)
			bcdwm_pkg::CFG_WAKE_TIMEOUT: begin
				wake_secs = value;
			end
			bcdwm_pkg::CFG_RETURN_TIMEOUT: begin
				return_secs = value;
			end
			bcdwm_pkg::CFG_LOCKOUT_TICKS: begin
				lockout_len = value[3:0];
			end
			default: begin
			end
		endcase
	endfunction

	function void advance_hour();
		hr_units = hr_units + 4'd1;
		if (hr_units >= 4'd10) begin
			hr_units = 4'd0;
			hr_tens = (hr_tens < 2'd2) ? hr_tens + 2'd1 : 2'd0;
		end
		if (hr_tens >= 2'd2 && hr_units >= 4'd4) begin
			hr_tens = 2'd0;
			hr_units = 4'd0;
		end
	endfunction

	function bit advance_minute();
		min_units = min_units + 4'd1;
		if (min_units >= 4'd10) begin
			min_units = 4'd0;
			min_tens = min_tens + 3'd1;
		end
		if (min_tens >= 3'd6) begin
			min_tens = 3'd0;
			min_units = 4'd0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function void count_one_second();
		sec_count = sec_count + 6'd1;
		if (sec_count >= bcdwm_pkg::SECONDS_PER_MINUTE) begin
			sec_count = 6'd0;
			if (advance_minute()) begin
				advance_hour();
				if (hr_tens == 2'd0 && hr_units == 4'd0)
					day_rollovers++;
			end
		end
	endfunction

	function void handle_tick();
		logic [3:0] limit;
		limit = (lockout_len == 4'd0) ? 4'd1 : lockout_len;
		if (!presses_open) begin
			lockout_seen = lockout_seen + 4'd1;
			if (lockout_seen >= limit) begin
				presses_open = 1'b1;
				lockout_seen = 4'd0;
			end
		end
		case (cur_mode)
			bcdwm_pkg::MODE_SLEEP: begin
				count_one_second();
			end
			bcdwm_pkg::MODE_DISPLAY: begin
				count_one_second();
				if (display_left <= 8'd1) begin
					display_left = 8'd0;
					cur_mode = bcdwm_pkg::MODE_SLEEP;
				end else begin
					display_left = display_left - 8'd1;
				end
			end
			bcdwm_pkg::MODE_SET_HOURS: begin
				advance_hour();
			end
			default: begin
				void'(advance_minute());
			end
		endcase
	endfunction

	// A press always wakes a sleeping watch; otherwise it only counts once the lockout is over.
	function void handle_press();
		if (cur_mode == bcdwm_pkg::MODE_SLEEP) begin
			cur_mode = bcdwm_pkg::MODE_DISPLAY;
			display_left = wake_secs;
			presses_open = 1'b0;
			mode_changes++;
			return;
		end
		if (!presses_open)
			return;
		presses_open = 1'b0;
		mode_changes++;
		case (cur_mode)
			bcdwm_pkg::MODE_DISPLAY: begin
				cur_mode = bcdwm_pkg::MODE_SET_HOURS;
			end
			bcdwm_pkg::MODE_SET_HOURS: begin
				cur_mode = bcdwm_pkg::MODE_SET_MINUTES;
			end
			default: begin
				cur_mode = bcdwm_pkg::MODE_DISPLAY;
				display_left = return_secs;
				sec_count = 6'd0;
			end
		endcase
	endfunction

	function void log_event(logic cmd, logic button);
		watch_face_t face;
		if (cmd == bcdwm_pkg::CMD_TICK) begin
			ticks++;
			handle_tick();
		end else begin
			samples++;
			if (button)
				handle_press();
		end
		face.mode = cur_mode;
		face.hour_tens = hr_tens;
		face.hour_units = hr_units;
		face.minute_tens = min_tens;
		face.minute_units = min_units;
		face.display_on = (cur_mode != bcdwm_pkg::MODE_SLEEP);
		pending_faces.push_back(face);
	endfunction

	function void compare_field(string name, int want, int got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	function void check_face(logic [bcdwm_pkg::OUT_DATA_W-1:0] word);
		watch_face_t want;
		if (pending_faces.size() == 0) begin
			errors++;
			$display("%0t: word %h arrived with no event outstanding, expected none, got %h",
				$time, word, word);
			return;
		end
		want = pending_faces.pop_front();
		faces_checked++;
		compare_field("mode", want.mode, word[bcdwm_pkg::OUT_MODE_LSB +: 2]);
		compare_field("hour_tens", want.hour_tens, word[bcdwm_pkg::OUT_HT_LSB +: 2]);
		compare_field("hour_units", want.hour_units, word[bcdwm_pkg::OUT_HU_LSB +: 4]);
		compare_field("minute_tens", want.minute_tens, word[bcdwm_pkg::OUT_MT_LSB +: 3]);
		compare_field("minute_units", want.minute_units, word[bcdwm_pkg::OUT_MU_LSB +: 4]);
		compare_field("display_on", want.display_on, word[bcdwm_pkg::OUT_DISP_BIT]);
	endfunction

	function int pending();
		return pending_faces.size();
	endfunction
endclass

module tb_bcd_watch_mode_controller;
	import bcdwm_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASE_EVENTS = 280;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
	logic                   s_axis_tuser = CMD_TICK;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0]  m_axis_tdata;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = CFG_WAKE_TIMEOUT;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	int sender_idle_pct = 0;
	int sink_stall_pct = 0;
	int cycle_count = 0;
	int events_sent = 0;

	watch_face_board board = new();

	bcd_watch_mode_controller DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				board.log_event(s_axis_tuser, s_axis_tdata[0]);
			if (m_axis_tvalid && m_axis_tready)
				board.check_face(m_axis_tdata);
		end
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d words outstanding", cycle_count,
				board.pending());
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_event(input logic cmd, input logic button);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {{(IN_DATA_W-1){1'b0}}, button};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		events_sent++;
	endtask

	// Ticks carry a random button bit; now and then a released button sample slips in.
	task automatic send_ticks(input int count);
		repeat (count) begin
			if ($urandom_range(9) == 0)
				send_event(CMD_BUTTON, 1'b0);
			else
				send_event(CMD_TICK, 1'($urandom_range(1)));
		end
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (board.pending() != 0);
		repeat (6) @(posedge clk);
	endtask

	task automatic load_config(input logic [7:0] wake, input logic [7:0] ret,
		input logic [7:0] lock);
		cfg_we <= 1'b1;
		cfg_index <= CFG_WAKE_TIMEOUT;
		cfg_data <= wake;
		@(posedge clk);
		board.write_reg(CFG_WAKE_TIMEOUT, wake);
		cfg_index <= CFG_RETURN_TIMEOUT;
		cfg_data <= ret;
		@(posedge clk);
		board.write_reg(CFG_RETURN_TIMEOUT, ret);
		cfg_index <= CFG_LOCKOUT_TICKS;
		cfg_data <= lock;
		@(posedge clk);
		board.write_reg(CFG_LOCKOUT_TICKS, lock);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Wake, set hours, set minutes, back to display, then let the clock run.
	task automatic watch_session();
		send_event(CMD_BUTTON, 1'b1);
		send_ticks($urandom_range(0, 20));
		send_event(CMD_BUTTON, 1'b1);
		send_ticks($urandom_range(0, 30));
		send_event(CMD_BUTTON, 1'b1);
		send_ticks($urandom_range(0, 70));
		send_event(CMD_BUTTON, 1'b1);
		if ($urandom_range(1) == 0)
			send_ticks($urandom_range(60, 90));
		else
			send_ticks($urandom_range(0, 40));
	endtask

	task automatic run_phase(input int n_events);
		int  first;
		bit  paused;
		first = events_sent;
		paused = 1'b0;
		while (events_sent - first < n_events) begin
			if ($urandom_range(99) < 75) begin
				watch_session();
			end else begin
				repeat ($urandom_range(1, 12))
					send_event(1'($urandom_range(1)), 1'($urandom_range(1)));
			end
			if (!paused && events_sent - first >= n_events / 2) begin
				settle();
				paused = 1'b1;
			end
		end
		settle();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Opening sequence with the reset settings: ignored inputs, lockout and the mode cycle.
		send_event(CMD_TICK, 1'b0);
		send_event(CMD_BUTTON, 1'b0);
		send_event(CMD_TICK, 1'b1);
		send_event(CMD_BUTTON, 1'b1);
		send_event(CMD_BUTTON, 1'b1);
		send_ticks(0);
		send_event(CMD_TICK, 1'b0);
		send_event(CMD_TICK, 1'b0);
		send_event(CMD_BUTTON, 1'b1);
		repeat (4) send_event(CMD_TICK, 1'b0);
		send_event(CMD_BUTTON, 1'b1);
		repeat (4) send_event(CMD_TICK, 1'b1);
		send_event(CMD_BUTTON, 1'b1);
		send_event(CMD_BUTTON, 1'b1);
		send_event(CMD_TICK, 1'b0);
		send_event(CMD_TICK, 1'b0);
		send_event(CMD_BUTTON, 1'b1);
		send_event(CMD_BUTTON, 1'b1);
		settle();

		load_config(8'd1, 8'd1, 8'd1);
		run_phase(PHASE_EVENTS);

		sender_idle_pct = 70;
		load_config(8'd255, 8'd255, 8'd15);
		run_phase(PHASE_EVENTS);

		sender_idle_pct = 0;
		sink_stall_pct = 70;
		load_config(8'd0, 8'd0, 8'd0);
		run_phase(PHASE_EVENTS);

		sender_idle_pct = 32;
		sink_stall_pct = 32;
		load_config(8'($urandom_range(2, 254)), 8'($urandom_range(2, 254)), 8'hF3);
		run_phase(PHASE_EVENTS);

		sender_idle_pct = 0;
		sink_stall_pct = 0;
		load_config(8'($urandom_range(2, 40)), 8'($urandom_range(2, 40)),
			{4'($urandom_range(15)), 4'($urandom_range(1, 15))});
		run_phase(PHASE_EVENTS);

		$display("Sent %0d events (%0d ticks, %0d button samples), checked %0d words.",
			events_sent, board.ticks, board.samples, board.faces_checked);
		$display("Mode changes taken: %0d, day rollovers: %0d, mismatches: %0d.",
			board.mode_changes, board.day_rollovers, board.errors);
		if (board.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
